### rtl/bsa_pkg.sv
`timescale 1ns / 1ps

package bsa_pkg;

    localparam int DEF_MAX_PROCESSES = 8;
    localparam int DEF_MAX_RESOURCES = 8;
    localparam int DEF_UNIT_BITS     = 8;

    localparam int CMD_W    = 3;
    localparam int PROC_W   = 4;
    localparam int RES_W    = 3;
    localparam int VALUE_W  = 8;
    localparam int STATUS_W = 3;
    localparam int SEQ_W    = 3;
    localparam int CFG_W    = 4;

    localparam logic [CMD_W-1:0] CMD_LOAD_ALLOC = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_MAX   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD_AVAIL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_STAGE      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SUBMIT     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CHECK      = 3'd5;

    localparam logic [STATUS_W-1:0] ST_LOADED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SAFE     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNSAFE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVER_MAX = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVER_AV  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_OVER_NEED = 3'd5;
    localparam logic [STATUS_W-1:0] ST_BAD_PROC = 3'd6;

    localparam logic REG_NUM_PROC = 1'b0;
    localparam logic REG_NUM_RES  = 1'b1;

    typedef enum logic [2:0] {
        CELL_NOP,
        CELL_WR_ALLOC,
        CELL_WR_MAX,
        CELL_ADD,
        CELL_SUB
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [PROC_W-1:0]   proc;
        logic [RES_W-1:0]    res;
        logic [VALUE_W-1:0]  value;
    } cell_cmd_t;

endpackage

### rtl/bsa_cell.sv
`timescale 1ns / 1ps

module bsa_cell #(
    parameter int MAX_RESOURCES = 8,
    parameter int UNIT_BITS     = 8,
    parameter int WORK_W        = 12,
    parameter int CNTP_W        = 4,
    parameter int CNTR_W        = 4,
    parameter int IDX           = 0
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  bsa_pkg::cell_cmd_t                           cmd_i,
    input  logic [MAX_RESOURCES-1:0][UNIT_BITS-1:0]      staged_i,
    input  logic [CNTP_W-1:0]                            np_i,
    input  logic [CNTR_W-1:0]                            nr_i,
    input  logic                                         clear_done_i,
    input  logic                                         tok_valid_i,
    input  logic [MAX_RESOURCES-1:0][WORK_W-1:0]         tok_work_i,
    output logic                                         tok_valid_o,
    output logic [MAX_RESOURCES-1:0][WORK_W-1:0]         tok_work_o,
    output logic                                         fire_o,
    output logic [MAX_RESOURCES-1:0][UNIT_BITS-1:0]      alloc_row_o,
    output logic [MAX_RESOURCES-1:0][UNIT_BITS-1:0]      max_row_o
);
    import bsa_pkg::*;

    logic [MAX_RESOURCES-1:0][UNIT_BITS-1:0] alloc_reg;
    logic [MAX_RESOURCES-1:0][UNIT_BITS-1:0] max_reg;
    logic                                    done_reg;
    logic                                    tok_valid_reg;
    logic [MAX_RESOURCES-1:0][WORK_W-1:0]    tok_work_reg;

    logic [MAX_RESOURCES-1:0][WORK_W-1:0]    work_sum;
    logic [MAX_RESOURCES-1:0]                fits_r;
    logic [MAX_RESOURCES-1:0]                in_use;
    logic [UNIT_BITS:0]                      need [MAX_RESOURCES];
    logic                                    active;
    logic                                    sel;
    logic [UNIT_BITS-1:0]                    load_v;
    logic [VALUE_W+15:0]                     value_ext;

    assign active    = IDX < int'(np_i);
    assign sel       = int'(cmd_i.proc) == IDX;
    assign value_ext = {16'b0, cmd_i.value};
    assign load_v    = value_ext[UNIT_BITS-1:0];

    always_comb begin
        for (int r = 0; r < MAX_RESOURCES; r++) begin
            in_use[r]   = r < int'(nr_i);
            need[r]     = {1'b0, max_reg[r]} - {1'b0, alloc_reg[r]};
            fits_r[r]   = !in_use[r] || need[r][UNIT_BITS]
                          || (WORK_W'(need[r][UNIT_BITS-1:0]) <= tok_work_i[r]);
            work_sum[r] = in_use[r] ? tok_work_i[r] + WORK_W'(alloc_reg[r]) : tok_work_i[r];
        end
    end

    assign fire_o      = tok_valid_i && active && !done_reg && (&fits_r);
    assign tok_valid_o = tok_valid_reg;
    assign tok_work_o  = tok_work_reg;
    assign alloc_row_o = alloc_reg;
    assign max_row_o   = max_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alloc_reg     <= '0;
            max_reg       <= '0;
            done_reg      <= 1'b0;
            tok_valid_reg <= 1'b0;
        end else begin
            tok_valid_reg <= tok_valid_i;
            if (clear_done_i) begin
                done_reg <= 1'b0;
            end else if (fire_o) begin
                done_reg <= 1'b1;
            end
            if (sel) begin
                for (int r = 0; r < MAX_RESOURCES; r++) begin
                    case (cmd_i.op)
                        CELL_WR_ALLOC: begin
                            if (int'(cmd_i.res) == r) alloc_reg[r] <= load_v;
                        end
                        CELL_WR_MAX: begin
                            if (int'(cmd_i.res) == r) max_reg[r] <= load_v;
                        end
                        CELL_ADD: begin
                            if (in_use[r]) alloc_reg[r] <= alloc_reg[r] + staged_i[r];
                        end
                        CELL_SUB: begin
                            if (in_use[r]) alloc_reg[r] <= alloc_reg[r] - staged_i[r];
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        tok_work_reg <= fire_o ? work_sum : tok_work_i;
    end

endmodule

### rtl/bsa_ctrl.sv
`timescale 1ns / 1ps

module bsa_ctrl #(
    parameter int MAX_PROCESSES = 8,
    parameter int MAX_RESOURCES = 8,
    parameter int UNIT_BITS     = 8,
    parameter int WORK_W        = 12,
    parameter int CNTP_W        = 4,
    parameter int CNTR_W        = 4
) (
    input  logic                                                  aclk,
    input  logic                                                  aresetn,
    input  logic                                                  s_tvalid,
    output logic                                                  s_tready,
    input  logic [23:0]                                           s_tdata,
    output logic                                                  m_tvalid,
    input  logic                                                  m_tready,
    output logic [7:0]                                            m_tdata,
    output logic                                                  m_tlast,
    input  logic                                                  cfg_wr_en,
    input  logic                                                  cfg_addr,
    input  logic [bsa_pkg::CFG_W-1:0]                             cfg_wdata,
    output bsa_pkg::cell_cmd_t                                    cell_cmd_o,
    output logic [MAX_RESOURCES-1:0][UNIT_BITS-1:0]               staged_o,
    output logic [CNTP_W-1:0]                                     np_o,
    output logic [CNTR_W-1:0]                                     nr_o,
    output logic                                                  clear_done_o,
    output logic                                                  tok_valid_o,
    output logic [MAX_RESOURCES-1:0][WORK_W-1:0]                  tok_work_o,
    input  logic                                                  tok_valid_i,
    input  logic [MAX_RESOURCES-1:0][WORK_W-1:0]                  tok_work_i,
    input  logic [MAX_PROCESSES-1:0]                              fire_i,
    input  logic [MAX_PROCESSES-1:0][MAX_RESOURCES-1:0][UNIT_BITS-1:0] alloc_rows_i,
    input  logic [MAX_PROCESSES-1:0][MAX_RESOURCES-1:0][UNIT_BITS-1:0] max_rows_i
);
    import bsa_pkg::*;

    localparam int PIDX = $clog2(MAX_PROCESSES);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_VERIFY   = 7'b0000010,
        S_LAUNCH   = 7'b0000100,
        S_SCAN     = 7'b0001000,
        S_ROLLBACK = 7'b0010000,
        S_EMIT     = 7'b0100000,
        S_SPARE    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [CNTP_W-1:0]                          np_reg;
    logic [CNTR_W-1:0]                          nr_reg;
    logic [MAX_RESOURCES-1:0][UNIT_BITS-1:0]    avail_reg;
    logic [MAX_RESOURCES-1:0][UNIT_BITS-1:0]    staged_reg;
    logic [PIDX-1:0]                            seq_reg [MAX_PROCESSES];
    logic [CNTP_W-1:0]                          cnt_reg;
    logic [CNTP_W-1:0]                          k_reg;
    logic                                       found_reg;
    logic [PROC_W-1:0]                          p_reg;
    logic                                       submit_reg;
    logic                                       tok_valid_reg;
    logic [MAX_RESOURCES-1:0][WORK_W-1:0]       tok_work_reg;
    logic                                       m_valid_reg;
    logic [STATUS_W-1:0]                        m_status_reg;
    logic [SEQ_W-1:0]                           m_seq_reg;
    logic                                       m_last_reg;

    logic [CMD_W-1:0]     in_cmd;
    logic [PROC_W-1:0]    in_proc;
    logic [RES_W-1:0]     in_res;
    logic [VALUE_W-1:0]   in_value;
    logic [VALUE_W+15:0]  value_ext;
    logic [UNIT_BITS-1:0] in_v;
    logic                 accept;
    logic                 out_free;
    logic                 p_ok;
    logic                 r_ok;
    logic                 fire_any;
    logic [PIDX-1:0]      fire_idx;
    logic [PIDX-1:0]      p_idx;
    logic [STATUS_W-1:0]  verify_status;
    logic                 verify_fail;
    logic [UNIT_BITS:0]   need_v;
    logic                 emit_last;
    logic [CNTP_W-1:0]    np_clamp;
    logic [CNTR_W-1:0]    nr_clamp;

    assign in_cmd    = s_tdata[2:0];
    assign in_proc   = s_tdata[6:3];
    assign in_res    = s_tdata[9:7];
    assign in_value  = s_tdata[17:10];
    assign value_ext = {16'b0, in_value};
    assign in_v      = value_ext[UNIT_BITS-1:0];

    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && out_free;
    assign accept    = s_tvalid && s_tready;
    assign p_ok      = int'(in_proc) < int'(np_reg);
    assign r_ok      = int'(in_res) < MAX_RESOURCES;
    assign p_idx     = PIDX'(p_reg);
    assign emit_last = CNTP_W'(k_reg + 1'b1) == np_reg;

    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {2'b0, m_seq_reg, m_status_reg};
    assign m_tlast   = m_last_reg;

    assign staged_o     = staged_reg;
    assign np_o         = np_reg;
    assign nr_o         = nr_reg;
    assign tok_valid_o  = tok_valid_reg;
    assign tok_work_o   = tok_work_reg;
    assign clear_done_o = state_reg == S_LAUNCH;

    always_comb begin
        if (cfg_wdata == '0) begin
            np_clamp = CNTP_W'(1);
            nr_clamp = CNTR_W'(1);
        end else begin
            np_clamp = (int'(cfg_wdata) > MAX_PROCESSES) ? CNTP_W'(MAX_PROCESSES)
                                                           : CNTP_W'(cfg_wdata);
            nr_clamp = (int'(cfg_wdata) > MAX_RESOURCES) ? CNTR_W'(MAX_RESOURCES)
                                                           : CNTR_W'(cfg_wdata);
        end
    end

    always_comb begin
        fire_any = |fire_i;
        fire_idx = '0;
        for (int i = 0; i < MAX_PROCESSES; i++) begin
            if (fire_i[i]) fire_idx = PIDX'(i);
        end
    end

    // first failing resource in index order wins
    always_comb begin
        verify_fail   = 1'b0;
        verify_status = ST_OVER_MAX;
        need_v        = '0;
        for (int r = MAX_RESOURCES - 1; r >= 0; r--) begin
            if (r < int'(nr_reg)) begin
                need_v = {1'b0, max_rows_i[p_idx][r]} - {1'b0, alloc_rows_i[p_idx][r]};
                if (max_rows_i[p_idx][r] < staged_reg[r]) begin
                    verify_fail   = 1'b1;
                    verify_status = ST_OVER_MAX;
                end else if (avail_reg[r] < staged_reg[r]) begin
                    verify_fail   = 1'b1;
                    verify_status = ST_OVER_AV;
                end else if (need_v[UNIT_BITS]
                             || (staged_reg[r] > need_v[UNIT_BITS-1:0])) begin
                    verify_fail   = 1'b1;
                    verify_status = ST_OVER_NEED;
                end
            end
        end
    end

    always_comb begin
        cell_cmd_o.op    = CELL_NOP;
        cell_cmd_o.proc  = in_proc;
        cell_cmd_o.res   = in_res;
        cell_cmd_o.value = in_value;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && p_ok && r_ok) begin
                    if (in_cmd == CMD_LOAD_ALLOC) cell_cmd_o.op = CELL_WR_ALLOC;
                    else if (in_cmd == CMD_LOAD_MAX) cell_cmd_o.op = CELL_WR_MAX;
                end
            end
            S_VERIFY: begin
                cell_cmd_o.proc = p_reg;
                if (!verify_fail) cell_cmd_o.op = CELL_ADD;
            end
            S_ROLLBACK: begin
                cell_cmd_o.proc = p_reg;
                cell_cmd_o.op   = CELL_SUB;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (in_cmd == CMD_SUBMIT && p_ok) state_next = S_VERIFY;
                    else if (in_cmd == CMD_CHECK) state_next = S_LAUNCH;
                end
            end
            S_VERIFY: state_next = verify_fail ? S_IDLE : S_LAUNCH;
            S_LAUNCH: state_next = S_SCAN;
            S_SCAN: begin
                if (tok_valid_i) begin
                    if (cnt_reg == np_reg) state_next = S_EMIT;
                    else if (!found_reg) state_next = submit_reg ? S_ROLLBACK : S_IDLE;
                end
            end
            S_ROLLBACK: state_next = S_IDLE;
            S_EMIT: begin
                if (out_free && emit_last) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            np_reg        <= CNTP_W'(1);
            nr_reg        <= CNTR_W'(1);
            avail_reg     <= '0;
            staged_reg    <= '0;
            tok_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            cnt_reg       <= '0;
            k_reg         <= '0;
            found_reg     <= 1'b0;
            submit_reg    <= 1'b0;
        end else begin
            state_reg     <= state_next;
            tok_valid_reg <= 1'b0;
            if (m_tready) m_valid_reg <= 1'b0;
            if (cfg_wr_en) begin
                if (cfg_addr == REG_NUM_PROC) np_reg <= np_clamp;
                else nr_reg <= nr_clamp;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        p_reg      <= in_proc;
                        submit_reg <= in_cmd == CMD_SUBMIT;
                        m_seq_reg  <= '0;
                        m_last_reg <= 1'b1;
                        case (in_cmd)
                            CMD_LOAD_ALLOC, CMD_LOAD_MAX: begin
                                m_valid_reg  <= 1'b1;
                                m_status_reg <= p_ok ? ST_LOADED : ST_BAD_PROC;
                            end
                            CMD_LOAD_AVAIL: begin
                                if (r_ok) avail_reg[RES_W'(in_res)] <= in_v;
                                m_valid_reg  <= 1'b1;
                                m_status_reg <= ST_LOADED;
                            end
                            CMD_STAGE: begin
                                if (r_ok) staged_reg[RES_W'(in_res)] <= in_v;
                                m_valid_reg  <= 1'b1;
                                m_status_reg <= ST_LOADED;
                            end
                            CMD_SUBMIT: begin
                                if (!p_ok) begin
                                    m_valid_reg  <= 1'b1;
                                    m_status_reg <= ST_BAD_PROC;
                                end
                            end
                            CMD_CHECK: begin
                            end
                            default: begin
                                m_valid_reg  <= 1'b1;
                                m_status_reg <= ST_UNSAFE;
                            end
                        endcase
                    end
                end
                S_VERIFY: begin
                    if (verify_fail) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= verify_status;
                        m_seq_reg    <= '0;
                        m_last_reg   <= 1'b1;
                    end else begin
                        for (int r = 0; r < MAX_RESOURCES; r++) begin
                            if (r < int'(nr_reg)) avail_reg[r] <= avail_reg[r] - staged_reg[r];
                        end
                    end
                end
                S_LAUNCH: begin
                    tok_valid_reg <= 1'b1;
                    cnt_reg       <= '0;
                    found_reg     <= 1'b0;
                    k_reg         <= '0;
                    for (int r = 0; r < MAX_RESOURCES; r++) begin
                        tok_work_reg[r] <= WORK_W'(avail_reg[r]);
                    end
                end
                S_SCAN: begin
                    if (fire_any) begin
                        seq_reg[cnt_reg[PIDX-1:0]] <= fire_idx;
                        cnt_reg   <= cnt_reg + 1'b1;
                        found_reg <= 1'b1;
                    end
                    if (tok_valid_i && cnt_reg != np_reg) begin
                        if (found_reg) begin
                            tok_valid_reg <= 1'b1;
                            tok_work_reg  <= tok_work_i;
                            found_reg     <= 1'b0;
                        end else if (!submit_reg) begin
                            m_valid_reg  <= 1'b1;
                            m_status_reg <= ST_UNSAFE;
                            m_seq_reg    <= '0;
                            m_last_reg   <= 1'b1;
                        end
                    end
                end
                S_ROLLBACK: begin
                    for (int r = 0; r < MAX_RESOURCES; r++) begin
                        if (r < int'(nr_reg)) avail_reg[r] <= avail_reg[r] + staged_reg[r];
                    end
                    m_valid_reg  <= 1'b1;
                    m_status_reg <= ST_UNSAFE;
                    m_seq_reg    <= '0;
                    m_last_reg   <= 1'b1;
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= ST_SAFE;
                        m_seq_reg    <= SEQ_W'(seq_reg[k_reg[PIDX-1:0]]);
                        m_last_reg   <= emit_last;
                        k_reg        <= k_reg + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

### rtl/bankers_safety_allocator_core.sv
`timescale 1ns / 1ps

// banker's algorithm engine: allocation and maximum-claim rows live in a chain of process
// cells, one per process; the safety check sends a work vector down the chain, one cell
// per cycle, and each unfinished process whose need fits takes its turn and adds its
// allocation. a load, stage or bad-process request is answered straight from the idle
// state; a safety check takes up to num_processes scans of the chain and then delivers
// the safe sequence one entry at a time; a submit adds a claim-check state before the scan
// and a roll-back state when the result is unsafe. one request is worked on at a time;
// the next is taken once the output register is empty or being read out
module bankers_safety_allocator_core #(
    parameter int MAX_PROCESSES = bsa_pkg::DEF_MAX_PROCESSES,
    parameter int MAX_RESOURCES = bsa_pkg::DEF_MAX_RESOURCES,
    parameter int UNIT_BITS     = bsa_pkg::DEF_UNIT_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [23:0]               s_tdata,   // command, process, resource, value
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [7:0]                m_tdata,   // status, sequence_process
    output logic                      m_tlast,
    input  logic                      cfg_wr_en,
    input  logic                      cfg_addr,
    input  logic [bsa_pkg::CFG_W-1:0] cfg_wdata
);
    import bsa_pkg::*;

    localparam int WORK_W = UNIT_BITS + $clog2(MAX_PROCESSES + 1);
    localparam int CNTP_W = $clog2(MAX_PROCESSES + 1);
    localparam int CNTR_W = $clog2(MAX_RESOURCES + 1);

    cell_cmd_t                                              cell_cmd;
    logic [MAX_RESOURCES-1:0][UNIT_BITS-1:0]                staged;
    logic [CNTP_W-1:0]                                      np;
    logic [CNTR_W-1:0]                                      nr;
    logic                                                   clear_done;
    logic [MAX_PROCESSES:0]                                 tok_valid;
    logic [MAX_PROCESSES:0][MAX_RESOURCES-1:0][WORK_W-1:0]  tok_work;
    logic [MAX_PROCESSES-1:0]                               fire;
    logic [MAX_PROCESSES-1:0][MAX_RESOURCES-1:0][UNIT_BITS-1:0] alloc_rows;
    logic [MAX_PROCESSES-1:0][MAX_RESOURCES-1:0][UNIT_BITS-1:0] max_rows;

    bsa_ctrl #(
        .MAX_PROCESSES (MAX_PROCESSES),
        .MAX_RESOURCES (MAX_RESOURCES),
        .UNIT_BITS     (UNIT_BITS),
        .WORK_W        (WORK_W),
        .CNTP_W        (CNTP_W),
        .CNTR_W        (CNTR_W)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .cell_cmd_o   (cell_cmd),
        .staged_o     (staged),
        .np_o         (np),
        .nr_o         (nr),
        .clear_done_o (clear_done),
        .tok_valid_o  (tok_valid[0]),
        .tok_work_o   (tok_work[0]),
        .tok_valid_i  (tok_valid[MAX_PROCESSES]),
        .tok_work_i   (tok_work[MAX_PROCESSES]),
        .fire_i       (fire),
        .alloc_rows_i (alloc_rows),
        .max_rows_i   (max_rows)
    );

    for (genvar i = 0; i < MAX_PROCESSES; i++) begin : g_cell
        bsa_cell #(
            .MAX_RESOURCES (MAX_RESOURCES),
            .UNIT_BITS     (UNIT_BITS),
            .WORK_W        (WORK_W),
            .CNTP_W        (CNTP_W),
            .CNTR_W        (CNTR_W),
            .IDX           (i)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .cmd_i        (cell_cmd),
            .staged_i     (staged),
            .np_i         (np),
            .nr_i         (nr),
            .clear_done_i (clear_done),
            .tok_valid_i  (tok_valid[i]),
            .tok_work_i   (tok_work[i]),
            .tok_valid_o  (tok_valid[i+1]),
            .tok_work_o   (tok_work[i+1]),
            .fire_o       (fire[i]),
            .alloc_row_o  (alloc_rows[i]),
            .max_row_o    (max_rows[i])
        );
    end

endmodule

### bench/bankers_safety_allocator_core_tb.sv
`timescale 1ns / 1ps

module bankers_safety_allocator_core_tb;
    import bsa_pkg::*;

    localparam int NPROC = 8;
    localparam int NRES  = 8;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [RES_W-1:0]   res;
        logic [PROC_W-1:0]  proc;
        logic [CMD_W-1:0]   cmd;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SEQ_W-1:0]    seq_proc;
        logic                last;
    } answer_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [23:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic m_tlast;
    logic cfg_wr_en = 1'b0;
    logic cfg_addr = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    bankers_safety_allocator_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // predictor state
    int unsigned n_proc, n_res;
    logic [7:0] alloc_tbl [NPROC*NRES];
    logic [7:0] claim_tbl [NPROC*NRES];
    logic [7:0] avail_vec [NRES];
    logic [7:0] staged_vec [NRES];

    request_t pending_requests[$];
    answer_t  expected_answers[$];
    int errors = 0;
    int accepted_count = 0;
    int sent_count = 0;
    int idle_cycles = 0;

    function automatic int need_of(int p, int r);
        return int'(claim_tbl[p*NRES+r]) - int'(alloc_tbl[p*NRES+r]);
    endfunction

    function automatic int unsigned clamp_count(logic [3:0] v, int unsigned bound);
        if (v == 0) return 1;
        if (v > bound) return bound;
        return v;
    endfunction

    function automatic void push_answer(logic [2:0] st, int sp, logic l);
        answer_t a;
        a.status = st;
        a.seq_proc = SEQ_W'(sp);
        a.last = l;
        expected_answers.push_back(a);
    endfunction

    // runs the safety scan; pushes the sequence or an unsafe answer, returns safe
    function automatic bit predict_safety();
        longint work [NRES];
        bit done [NPROC];
        int order [NPROC];
        int count;
        bit found, fits;
        count = 0;
        for (int r = 0; r < NRES; r++) work[r] = avail_vec[r];
        for (int p = 0; p < NPROC; p++) done[p] = 0;
        while (count < n_proc) begin
            found = 0;
            for (int p = 0; p < n_proc; p++) begin
                if (!done[p]) begin
                    fits = 1;
                    for (int r = 0; r < n_res; r++)
                        if (need_of(p, r) > work[r]) fits = 0;
                    if (fits) begin
                        for (int r = 0; r < n_res; r++) work[r] += alloc_tbl[p*NRES+r];
                        done[p] = 1;
                        order[count] = p;
                        count++;
                        found = 1;
                    end
                end
            end
            if (!found) begin
                push_answer(ST_UNSAFE, 0, 1'b1);
                return 0;
            end
        end
        for (int i = 0; i < n_proc; i++)
            push_answer(ST_SAFE, order[i], i + 1 == n_proc);
        return 1;
    endfunction

    function automatic void predict_submit(int p);
        for (int r = 0; r < n_res; r++) begin
            if (claim_tbl[p*NRES+r] < staged_vec[r]) begin
                push_answer(ST_OVER_MAX, 0, 1'b1);
                return;
            end
            if (avail_vec[r] < staged_vec[r]) begin
                push_answer(ST_OVER_AV, 0, 1'b1);
                return;
            end
            if (int'(staged_vec[r]) > need_of(p, r)) begin
                push_answer(ST_OVER_NEED, 0, 1'b1);
                return;
            end
        end
        for (int r = 0; r < n_res; r++) begin
            alloc_tbl[p*NRES+r] += staged_vec[r];
            avail_vec[r] -= staged_vec[r];
        end
        if (!predict_safety()) begin
            for (int r = 0; r < n_res; r++) begin
                alloc_tbl[p*NRES+r] -= staged_vec[r];
                avail_vec[r] += staged_vec[r];
            end
        end
    endfunction

    function automatic void predict_request(request_t q);
        bit p_ok;
        p_ok = q.proc < n_proc;
        case (q.cmd)
            CMD_LOAD_ALLOC, CMD_LOAD_MAX: begin
                if (!p_ok) begin
                    push_answer(ST_BAD_PROC, 0, 1'b1);
                end else begin
                    if (q.cmd == CMD_LOAD_ALLOC) alloc_tbl[q.proc*NRES+q.res] = q.value;
                    else claim_tbl[q.proc*NRES+q.res] = q.value;
                    push_answer(ST_LOADED, 0, 1'b1);
                end
            end
            CMD_LOAD_AVAIL: begin
                avail_vec[q.res] = q.value;
                push_answer(ST_LOADED, 0, 1'b1);
            end
            CMD_STAGE: begin
                staged_vec[q.res] = q.value;
                push_answer(ST_LOADED, 0, 1'b1);
            end
            CMD_SUBMIT: begin
                if (!p_ok) push_answer(ST_BAD_PROC, 0, 1'b1);
                else predict_submit(q.proc);
            end
            CMD_CHECK: void'(predict_safety());
            default: push_answer(ST_UNSAFE, 0, 1'b1);
        endcase
    endfunction

    function automatic request_t make_req(int c, int p, int r, int v);
        request_t q;
        q.cmd = CMD_W'(c);
        q.proc = PROC_W'(p);
        q.res = RES_W'(r);
        q.value = VALUE_W'(v);
        return q;
    endfunction

    // driver
    int send_gap = 0;
    bit hold_off = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && accepted_count != sent_count) begin
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (!hold_off && pending_requests.size() > 0) begin
                s_tdata <= 24'(pending_requests.pop_front());
                s_tvalid <= 1'b1;
                sent_count <= sent_count + 1;
                send_gap <= $urandom_range(0, 3);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // prediction at acceptance
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            predict_request(request_t'(s_tdata[17:0]));
            accepted_count <= accepted_count + 1;
        end
    end

    // monitor
    int stall = 0;
    always @(posedge aclk) begin
        answer_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.status = m_tdata[2:0];
                got.seq_proc = m_tdata[5:3];
                got.last = m_tlast;
                if (expected_answers.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, got);
                    errors++;
                end else begin
                    want = expected_answers.pop_front();
                    if (got.status !== want.status || got.seq_proc !== want.seq_proc ||
                        got.last !== want.last) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, got);
                        errors++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    always @(negedge aclk) begin
        if (m_tvalid && m_tready || !m_tready) begin
            if (stall > 0) begin
                stall <= stall - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                stall <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
            end
        end
    end

    always @(posedge aclk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_requests.size() > 0 || s_tvalid || expected_answers.size() > 0)
            @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [3:0] v);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_NUM_PROC) n_proc = clamp_count(v, NPROC);
        else n_res = clamp_count(v, NRES);
    endtask

    // well-formed scenario: sensible tables then requests
    task automatic queue_scenario();
        for (int p = 0; p < n_proc; p++)
            for (int r = 0; r < n_res; r++) begin
                int c, a;
                c = $urandom_range(0, 9);
                a = $urandom_range(0, c);
                pending_requests.push_back(make_req(CMD_LOAD_MAX, p, r, c));
                pending_requests.push_back(make_req(CMD_LOAD_ALLOC, p, r, a));
            end
        for (int r = 0; r < n_res; r++)
            pending_requests.push_back(make_req(CMD_LOAD_AVAIL, 0, r, $urandom_range(0, 8)));
        pending_requests.push_back(make_req(CMD_CHECK, 0, 0, 0));
        repeat (4) begin
            for (int r = 0; r < n_res; r++)
                pending_requests.push_back(make_req(CMD_STAGE, $urandom, r,
                                                    $urandom_range(0, 3)));
            pending_requests.push_back(make_req(CMD_SUBMIT,
                                                $urandom_range(0, n_proc - 1), 0, 0));
        end
    endtask

    task automatic queue_noise(int k);
        repeat (k) begin
            pending_requests.push_back(make_req($urandom_range(0, 7), $urandom_range(0, 15),
                                                $urandom_range(0, 7), $urandom_range(0, 255)));
        end
    endtask

    initial begin
        int phase_sizes [5][2] = '{'{1, 1}, '{15, 2}, '{0, 0}, '{2, 15}, '{5, 3}};
        n_proc = 1;
        n_res = 1;
        for (int i = 0; i < NPROC*NRES; i++) begin
            alloc_tbl[i] = 0;
            claim_tbl[i] = 0;
        end
        for (int r = 0; r < NRES; r++) begin
            avail_vec[r] = 0;
            staged_vec[r] = 0;
        end
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: defaults, extremes, every command, bad process, unused codes
        pending_requests.push_back(make_req(CMD_CHECK, 0, 0, 0));
        pending_requests.push_back(make_req(CMD_LOAD_ALLOC, 0, 7, 8'hff));
        pending_requests.push_back(make_req(CMD_LOAD_MAX, 0, 0, 8'hff));
        pending_requests.push_back(make_req(CMD_LOAD_ALLOC, 15, 0, 1));
        pending_requests.push_back(make_req(CMD_LOAD_MAX, 1, 0, 1));
        pending_requests.push_back(make_req(CMD_LOAD_AVAIL, 15, 7, 8'hff));
        pending_requests.push_back(make_req(CMD_LOAD_AVAIL, 0, 0, 8'h0f));
        pending_requests.push_back(make_req(CMD_STAGE, 9, 0, 8'h10));
        pending_requests.push_back(make_req(CMD_SUBMIT, 0, 0, 0));
        pending_requests.push_back(make_req(CMD_STAGE, 0, 0, 8'h05));
        pending_requests.push_back(make_req(CMD_SUBMIT, 0, 0, 0));
        pending_requests.push_back(make_req(CMD_SUBMIT, 1, 0, 0));
        pending_requests.push_back(make_req(CMD_SUBMIT, 15, 0, 0));
        pending_requests.push_back(make_req(CMD_LOAD_ALLOC, 0, 0, 8'hff));
        pending_requests.push_back(make_req(CMD_STAGE, 0, 0, 8'h01));
        pending_requests.push_back(make_req(CMD_SUBMIT, 0, 0, 0));
        pending_requests.push_back(make_req(CMD_LOAD_MAX, 0, 0, 8'h00));
        pending_requests.push_back(make_req(CMD_CHECK, 0, 0, 0));
        pending_requests.push_back(make_req(6, 4'ha, 5, 8'haa));
        pending_requests.push_back(make_req(7, 4'h5, 2, 8'h55));
        pending_requests.push_back(make_req(CMD_LOAD_ALLOC, 0, 0, 8'h00));
        wait_drained();

        // queue noise with the sender held off, then release it
        hold_off = 1;
        queue_noise(2);
        repeat (40) @(posedge aclk);
        hold_off = 0;
        wait_drained();

        foreach (phase_sizes[i]) begin
            write_reg(REG_NUM_PROC, 4'(phase_sizes[i][0]));
            write_reg(REG_NUM_RES, 4'(phase_sizes[i][1]));
            queue_scenario();
            queue_noise(10);
            if (n_proc * n_res <= 12) queue_scenario();
            wait_drained();
        end

        if (errors == 0 && expected_answers.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
